// ===== design/nq_pkg.sv =====
// ---------------------------------------------------------------------------
// nq_pkg: shared constants for the N-queens search block
// Field widths, board size limits and default settings.
// ---------------------------------------------------------------------------
package nq_pkg;

    // Queen column, one nibble per row in the placement
    localparam int COL_W          = 4;
    // Width of the column/row compare datapath (columns up to 16)
    localparam int CALC_W         = 5;
    // Solution counter
    localparam int COUNT_W        = 14;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    // Board size register
    localparam int SIZE_W         = 4;
    localparam int SIZE_LOW       = 4;
    localparam int SIZE_HIGH      = 12;
    localparam logic [SIZE_W-1:0] DEF_BOARD_SIZE = 4'd8;
    // Largest board the column stack holds
    localparam int DEF_MAX_BOARD  = 12;

endpackage

// ===== design/n_queens_backtracking_search.sv =====
// ---------------------------------------------------------------------------
// n_queens_backtracking_search: resumable N-queens solver
// Depth-first search over a per-row column stack. Each request restarts or
// resumes the walk and returns the next placement, or reports exhaustion.
// ---------------------------------------------------------------------------
//
//  channel | direction | word contents (lowest bit first)
//  --------+-----------+------------------------------------------------------
//  s_      | in        | restart
//  m_      | out       | found, placement, solution_number, zero pad
//  cfg_    | in        | board_size (write clears the search)
//
//  A request is accepted, then walks the search: a scan step per column
//  tried or row backtracked, a check step per earlier row compared by the
//  single diagonal/column compare unit and a last check step to place a
//  legal column; the result word is then emitted.
//  Reset clears the search and sets board_size to 8; the stack holds no reset.
//  s_tready is low while a search runs, a result word waits in the output
//  register or a board_size write is offered; a stalled m_ side holds the
//  result word stable.
//
module n_queens_backtracking_search
    import nq_pkg::*;
#(
    parameter int MAX_BOARD = DEF_MAX_BOARD
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request: [0] restart
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    // result: [0] found, [4*MAX_BOARD:1] placement,
    //         [4*MAX_BOARD+14:4*MAX_BOARD+1] solution_number, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((1+COL_W*MAX_BOARD+COUNT_W+7)/8)*8-1:0] m_tdata,
    // board_size write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     cfg_data
);

    localparam int PLACE_W = COL_W * MAX_BOARD;
    localparam int RES_W   = 1 + PLACE_W + COUNT_W;
    localparam int DATA_W  = ((RES_W + 7) / 8) * 8;
    localparam int ROW_W   = $clog2(MAX_BOARD + 1);
    localparam int IDX_W   = $clog2(MAX_BOARD);
    localparam int N_HIGH  = (SIZE_HIGH < MAX_BOARD) ? SIZE_HIGH : MAX_BOARD;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [CALC_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]     chk_reg, chk_next;
    logic [ROW_W-1:0]     held_row_reg, held_row_next;
    logic                 exhausted_reg, exhausted_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 found_reg, found_next;
    logic                 m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]    m_data_reg, m_data_next;
    logic [COL_W-1:0]     stack_reg [MAX_BOARD];

    logic [ROW_W-1:0]     n_eff;
    logic [IDX_W-1:0]     rd_idx;
    logic [COL_W-1:0]     rd_col;
    logic [CALC_W-1:0]    q_ext, row_gap, dcol;
    logic                 conflict;
    logic                 stack_we;
    logic [PLACE_W-1:0]   placement;

    // Saturate board size to the supported range
    always_comb begin
        if (int'(size_reg) < SIZE_LOW) begin
            n_eff = ROW_W'(SIZE_LOW);
        end else if (int'(size_reg) > N_HIGH) begin
            n_eff = ROW_W'(N_HIGH);
        end else begin
            n_eff = ROW_W'(size_reg);
        end
    end

    // Single stack read port: backtrack row in scan, compared row in check
    assign rd_idx = (state_reg == ST_SCAN) ? IDX_W'(row_reg - ROW_W'(1))
                                           : chk_reg[IDX_W-1:0];
    assign rd_col = stack_reg[rd_idx];

    // Shared compare unit: same column or shared diagonal
    assign q_ext    = CALC_W'(rd_col);
    assign row_gap  = CALC_W'(row_reg - chk_reg);
    assign dcol     = (q_ext > col_reg) ? (q_ext - col_reg) : (col_reg - q_ext);
    assign conflict = (q_ext == col_reg) || (dcol == row_gap);

    // Gather placement from the stack, rows beyond N read as zero
    always_comb begin
        for (int r = 0; r < MAX_BOARD; r++) begin
            placement[r*COL_W +: COL_W] = (r < int'(n_eff)) ? stack_reg[r] : '0;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE) && !m_valid_reg && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        size_next      = size_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        chk_next       = chk_reg;
        held_row_next  = held_row_reg;
        exhausted_next = exhausted_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        stack_we       = 1'b0;

        // Drop the result word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    size_next      = cfg_data;
                    held_row_next  = '0;
                    exhausted_next = 1'b0;
                    count_next     = '0;
                end else if (s_tvalid && s_tready) begin
                    if (s_tdata[0]) begin
                        // Restart: fresh search from row 0
                        count_next = '0;
                        row_next   = '0;
                        col_next   = '0;
                        state_next = ST_SCAN;
                    end else if (exhausted_reg) begin
                        found_next = 1'b0;
                        state_next = ST_EMIT;
                    end else begin
                        // Resume: fresh search starts at row 0, column 0;
                        // otherwise a column past N forces backtrack from last row
                        row_next   = held_row_reg;
                        col_next   = (held_row_reg == '0) ? '0 : CALC_W'(n_eff);
                        state_next = ST_SCAN;
                    end
                    if (s_tdata[0]) begin
                        exhausted_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (col_reg >= CALC_W'(n_eff)) begin
                    if (row_reg == '0) begin
                        exhausted_next = 1'b1;
                        held_row_next  = '0;
                        found_next     = 1'b0;
                        state_next     = ST_EMIT;
                    end else begin
                        // Backtrack one row and try its next column
                        row_next = row_reg - ROW_W'(1);
                        col_next = CALC_W'(rd_col) + CALC_W'(1);
                    end
                end else begin
                    chk_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (chk_reg == row_reg) begin
                    // Legal: push column, then advance a row or emit the solution
                    stack_we = 1'b1;
                    if (row_reg + ROW_W'(1) == n_eff) begin
                        held_row_next = n_eff;
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        found_next = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        row_next   = row_reg + ROW_W'(1);
                        col_next   = '0;
                        state_next = ST_SCAN;
                    end
                end else if (conflict) begin
                    col_next   = col_reg + CALC_W'(1);
                    state_next = ST_SCAN;
                end else begin
                    chk_next = chk_reg + ROW_W'(1);
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = DATA_W'({count_reg,
                                            found_reg ? placement : {PLACE_W{1'b0}},
                                            found_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            size_reg      <= DEF_BOARD_SIZE;
            held_row_reg  <= '0;
            exhausted_reg <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            held_row_reg  <= held_row_next;
            exhausted_reg <= exhausted_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        chk_reg    <= chk_next;
        found_reg  <= found_next;
        m_data_reg <= m_data_next;
        if (stack_we) begin
            stack_reg[row_reg[IDX_W-1:0]] <= col_reg[COL_W-1:0];
        end
    end

endmodule
